// ===== sv/srpd_pkg.sv =====
// ----------------------------------------------------------------------------
// srpd_pkg: shared definitions for the sprite run-length / planar decoder
// Register indexes, record kinds, queue command codes and the command type
// that passes from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package srpd_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // Record kinds on the result channel.
  localparam logic [1:0] KIND_PIXEL   = 2'd0;
  localparam logic [1:0] KIND_FILL    = 2'd1;
  localparam logic [1:0] KIND_ROW_END = 2'd2;

  // Command codes in the queue.
  localparam logic [1:0] OP_PIXEL   = 2'd0;
  localparam logic [1:0] OP_FILL    = 2'd1;
  localparam logic [1:0] OP_ROW_END = 2'd2;
  localparam logic [1:0] OP_BLOCK   = 2'd3;

  localparam logic [7:0] TRANSPARENT = 8'hff;

  // Default depth of the command queue.
  localparam int QUEUE_DEPTH = 4;

  // One queued command. For a planar block, val holds the last plane byte.
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] addr;
    logic [7:0]  len;
    logic [7:0]  val;
    logic        done;
    logic        row_end;
    logic [15:0] row_addr;
    logic [7:0]  mask;
    logic [7:0]  plane0;
    logic [7:0]  plane1;
    logic [7:0]  plane2;
  } cmd_t;

endpackage

`default_nettype wire

// ===== sv/srpd_queue.sv =====
// ----------------------------------------------------------------------------
// srpd_queue: command queue between front and back end
// A small first-in first-out buffer of decoded commands in flip-flops.
// ----------------------------------------------------------------------------
`default_nettype none

module srpd_queue #(
  parameter int DEPTH = srpd_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  srpd_pkg::cmd_t      push_data,
  output logic                full,
  input  wire logic           pop,
  output srpd_pkg::cmd_t      pop_data,
  output logic                empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  srpd_pkg::cmd_t  entry_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/srpd_front.sv =====
// ----------------------------------------------------------------------------
// srpd_front: byte classifier and position tracker
// Holds the configuration, takes a byte per cycle while the queue has room,
// tracks literal run, row and write position, queues pixel/fill/row end/block.
// ----------------------------------------------------------------------------
`default_nettype none

module srpd_front (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  output logic             push,
  output srpd_pkg::cmd_t   push_data,
  input  wire logic        q_full
);

  logic        mode_r, mode_nxt;
  logic [7:0]  width_r, width_nxt;
  logic [7:0]  height_r, height_nxt;
  logic [15:0] end_r, end_nxt;
  logic [6:0]  lit_left_r, lit_left_nxt;
  logic [7:0]  row_index_r, row_index_nxt;
  logic [15:0] wpos_r, wpos_nxt;
  logic [15:0] row_base_r, row_base_nxt;
  logic [2:0]  bbi_r, bbi_nxt;
  logic        finished_r, finished_nxt;
  logic [7:0]  plane_r [4];

  logic        restart;
  logic [7:0]  w_new, h_new;
  logic [8:0]  stride_new, stride;
  logic        accept, active;
  logic [15:0] room;
  logic [7:0]  fill_cnt, fill_clip;
  logic [7:0]  row_next;
  logic        row_done;
  logic [15:0] row_base_step;
  logic [15:0] wpos_plus8, row_span;
  logic        block_eor;
  logic        do_row_end;
  logic        plane_we;

  assign restart = cfg_we && (cfg_index == srpd_pkg::REG_MODE ||
                              cfg_index == srpd_pkg::REG_WIDTH ||
                              cfg_index == srpd_pkg::REG_HEIGHT);

  // Store end is worked out once when a register is written.
  always_comb begin
    w_new      = (cfg_we && cfg_index == srpd_pkg::REG_WIDTH)  ? cfg_wdata : width_r;
    h_new      = (cfg_we && cfg_index == srpd_pkg::REG_HEIGHT) ? cfg_wdata : height_r;
    stride_new = ({1'b0, w_new} + 9'd7) & ~9'd7;
    end_nxt    = restart ? 16'(stride_new * h_new) : end_r;
    mode_nxt   = (cfg_we && cfg_index == srpd_pkg::REG_MODE) ? cfg_wdata[0] : mode_r;
    width_nxt  = w_new;
    height_nxt = h_new;
  end

  assign stride   = ({1'b0, width_r} + 9'd7) & ~9'd7;
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign active   = !finished_r && (width_r != 8'd0) && (height_r != 8'd0);

  assign room          = (end_r > wpos_r) ? (end_r - wpos_r) : 16'd0;
  assign fill_cnt      = ~in_data_byte + 8'd1;
  assign fill_clip     = (room < {8'd0, fill_cnt}) ? room[7:0] : fill_cnt;
  assign row_next      = row_index_r + 8'd1;
  assign row_done      = (row_next >= height_r);
  assign row_base_step = row_base_r + {7'd0, stride};
  assign wpos_plus8    = wpos_r + 16'd8;
  assign row_span      = wpos_plus8 - row_base_r;
  assign block_eor     = (row_span >= {7'd0, stride});

  always_comb begin
    lit_left_nxt  = lit_left_r;
    row_index_nxt = row_index_r;
    wpos_nxt      = wpos_r;
    row_base_nxt  = row_base_r;
    bbi_nxt       = bbi_r;
    finished_nxt  = finished_r;
    do_row_end    = 1'b0;
    plane_we      = 1'b0;
    push          = 1'b0;
    push_data          = '0;
    push_data.addr     = wpos_r;
    push_data.val      = in_data_byte;
    push_data.row_addr = row_base_r;
    push_data.done     = row_done;
    push_data.mask     = plane_r[0];
    push_data.plane0   = plane_r[1];
    push_data.plane1   = plane_r[2];
    push_data.plane2   = plane_r[3];

    if (accept && active) begin
      if (mode_r) begin
        priority if (lit_left_r != 7'd0) begin
          push           = 1'b1;
          push_data.op   = srpd_pkg::OP_PIXEL;
          push_data.len  = 8'd1;
          wpos_nxt       = wpos_r + 16'd1;
          lit_left_nxt   = lit_left_r - 7'd1;
        end else if (in_data_byte == 8'd0) begin
          push           = 1'b1;
          push_data.op   = srpd_pkg::OP_ROW_END;
          push_data.addr = row_base_r;
          do_row_end     = 1'b1;
        end else if (!in_data_byte[7]) begin
          lit_left_nxt = (room < {9'd0, in_data_byte[6:0]}) ? room[6:0] : in_data_byte[6:0];
        end else begin
          // A fill clipped to nothing leaves no record.
          push          = (fill_clip != 8'd0);
          push_data.op  = srpd_pkg::OP_FILL;
          push_data.len = fill_clip;
          push_data.val = srpd_pkg::TRANSPARENT;
          wpos_nxt      = wpos_r + {8'd0, fill_clip};
        end
      end else begin
        if (bbi_r < 3'd4) begin
          plane_we = 1'b1;
          bbi_nxt  = bbi_r + 3'd1;
        end else begin
          bbi_nxt           = 3'd0;
          push              = 1'b1;
          push_data.op      = srpd_pkg::OP_BLOCK;
          push_data.len     = 8'd1;
          push_data.row_end = block_eor;
          wpos_nxt          = wpos_plus8;
          do_row_end        = block_eor;
        end
      end
    end

    if (do_row_end) begin
      row_index_nxt = row_next;
      finished_nxt  = finished_r || row_done;
      row_base_nxt  = row_base_step;
      wpos_nxt      = row_base_step;
      lit_left_nxt  = 7'd0;
    end

    if (restart) begin
      lit_left_nxt  = 7'd0;
      row_index_nxt = 8'd0;
      wpos_nxt      = 16'd0;
      row_base_nxt  = 16'd0;
      bbi_nxt       = 3'd0;
      finished_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b1;
      width_r     <= 8'd1;
      height_r    <= 8'd1;
      end_r       <= 16'd8;
      lit_left_r  <= 7'd0;
      row_index_r <= 8'd0;
      wpos_r      <= 16'd0;
      row_base_r  <= 16'd0;
      bbi_r       <= 3'd0;
      finished_r  <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      end_r       <= end_nxt;
      lit_left_r  <= lit_left_nxt;
      row_index_r <= row_index_nxt;
      wpos_r      <= wpos_nxt;
      row_base_r  <= row_base_nxt;
      bbi_r       <= bbi_nxt;
      finished_r  <= finished_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (plane_we) begin
      plane_r[bbi_r[1:0]] <= in_data_byte;
    end
  end

endmodule

`default_nettype wire

// ===== sv/srpd_back.sv =====
// ----------------------------------------------------------------------------
// srpd_back: record generator
// Takes commands from the queue and emits one record per cycle, while the
// output is not stalled, into the output register: one for a pixel, fill or
// row end, eight or nine for a planar block.
// ----------------------------------------------------------------------------
`default_nettype none

module srpd_back (
  input  wire logic        clk,
  input  wire logic        rst_n,
  output logic             pop,
  input  srpd_pkg::cmd_t   pop_data,
  input  wire logic        q_empty,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_record_kind,
  output logic [15:0]      out_pixel_address,
  output logic [7:0]       out_run_length,
  output logic [7:0]       out_pixel_value,
  output logic             out_sprite_done
);

  srpd_pkg::cmd_t cur_r, cur_nxt;
  logic           cur_valid_r, cur_valid_nxt;
  logic [3:0]     idx_r, idx_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [1:0]     kind_r;
  logic [15:0]    addr_r;
  logic [7:0]     len_r, val_r;
  logic           done_r;

  logic           slot_free, advance, last;
  logic [2:0]     sh;
  logic [1:0]     rec_kind;
  logic [15:0]    rec_addr;
  logic [7:0]     rec_len, rec_val;
  logic           rec_done;

  assign slot_free = !out_valid_r || !out_stall;
  assign advance   = cur_valid_r && slot_free;
  assign sh        = 3'd7 - idx_r[2:0];

  always_comb begin
    rec_kind = srpd_pkg::KIND_PIXEL;
    rec_addr = cur_r.addr;
    rec_len  = 8'd1;
    rec_val  = cur_r.val;
    rec_done = 1'b0;
    last     = 1'b1;
    unique case (cur_r.op)
      srpd_pkg::OP_PIXEL: begin
      end
      srpd_pkg::OP_FILL: begin
        rec_kind = srpd_pkg::KIND_FILL;
        rec_len  = cur_r.len;
        rec_val  = srpd_pkg::TRANSPARENT;
      end
      srpd_pkg::OP_ROW_END: begin
        rec_kind = srpd_pkg::KIND_ROW_END;
        rec_len  = 8'd0;
        rec_val  = 8'd0;
        rec_done = cur_r.done;
      end
      srpd_pkg::OP_BLOCK: begin
        if (idx_r[3]) begin
          // Row end that closes the row after its last block.
          rec_kind = srpd_pkg::KIND_ROW_END;
          rec_addr = cur_r.row_addr;
          rec_len  = 8'd0;
          rec_val  = 8'd0;
          rec_done = cur_r.done;
        end else begin
          rec_addr = cur_r.addr + {12'd0, idx_r};
          rec_val  = cur_r.mask[sh] ? srpd_pkg::TRANSPARENT :
                     {4'd0, cur_r.val[sh], cur_r.plane2[sh],
                      cur_r.plane1[sh], cur_r.plane0[sh]};
          last     = (idx_r[2:0] == 3'd7) && !cur_r.row_end;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    pop           = (!cur_valid_r || (advance && last)) && !q_empty;
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (pop) begin
      cur_nxt       = pop_data;
      cur_valid_nxt = 1'b1;
      idx_nxt       = 4'd0;
    end else if (advance && last) begin
      cur_valid_nxt = 1'b0;
    end else if (advance) begin
      idx_nxt = idx_r + 4'd1;
    end
    out_valid_nxt = advance ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (advance) begin
      kind_r <= rec_kind;
      addr_r <= rec_addr;
      len_r  <= rec_len;
      val_r  <= rec_val;
      done_r <= rec_done;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_record_kind   = kind_r;
  assign out_pixel_address = addr_r;
  assign out_run_length    = len_r;
  assign out_pixel_value   = val_r;
  assign out_sprite_done   = done_r;

endmodule

`default_nettype wire

// ===== sv/sprite_rle_planar_decoder.sv =====
// ----------------------------------------------------------------------------
// sprite_rle_planar_decoder: sprite byte stream to frame store write records
// Decodes run-length or planar sprite data into pixel, fill and row end
// records for a frame store whose row stride is the width rounded up to 8.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  in_data_byte
//   out      output     out_valid/out_stall kind, address, length, value, done
//   cfg      input      cfg_we             cfg_index, cfg_wdata
//
// A byte is taken every cycle while the command queue has room. The back
// end emits one record per cycle while out_stall is low, so planar data,
// which gives 8 or 9 records per 5-byte block, is paced by the back end.
// A byte's command is registered in the queue and in the back end's current
// command register, and each record in the output register.
// Reset is synchronous and needs no clearing pass; the queue lets either side
// stall while the other keeps working.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_rle_planar_decoder #(
  parameter int QUEUE_DEPTH = srpd_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_record_kind,
  output logic [15:0]      out_pixel_address,
  output logic [7:0]       out_run_length,
  output logic [7:0]       out_pixel_value,
  output logic             out_sprite_done
);

  srpd_pkg::cmd_t push_data, pop_data;
  logic           push, pop, q_full, q_empty;

  srpd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .push         (push),
    .push_data    (push_data),
    .q_full       (q_full)
  );

  srpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  srpd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .pop               (pop),
    .pop_data          (pop_data),
    .q_empty           (q_empty),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_record_kind   (out_record_kind),
    .out_pixel_address (out_pixel_address),
    .out_run_length    (out_run_length),
    .out_pixel_value   (out_pixel_value),
    .out_sprite_done   (out_sprite_done)
  );

endmodule

`default_nettype wire

// ===== sv/srpd_checker.sv =====
// ----------------------------------------------------------------------------
// srpd_checker: port-level checks for the sprite decoder
// Watches the result channel for stall behavior and record consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module srpd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_record_kind,
  input wire logic [15:0] out_pixel_address,
  input wire logic [7:0]  out_run_length,
  input wire logic [7:0]  out_pixel_value,
  input wire logic        out_sprite_done
);

  // A stalled result transaction keeps its record.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_record_kind) &&
      $stable(out_pixel_address) && $stable(out_run_length) &&
      $stable(out_pixel_value) && $stable(out_sprite_done))
    else $error("result changed while stalled");

  a_done_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sprite_done |-> out_record_kind == srpd_pkg::KIND_ROW_END)
    else $error("sprite done outside a row end record");

  a_pixel_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_kind == srpd_pkg::KIND_PIXEL |-> out_run_length == 8'd1)
    else $error("pixel record with length other than one");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_kind == srpd_pkg::KIND_FILL |->
      out_pixel_value == srpd_pkg::TRANSPARENT && out_run_length != 8'd0 &&
      out_run_length <= 8'd128)
    else $error("malformed fill record");

  a_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_kind == srpd_pkg::KIND_ROW_END |->
      out_run_length == 8'd0 && out_pixel_value == 8'd0)
    else $error("malformed row end record");

endmodule

bind sprite_rle_planar_decoder srpd_checker u_srpd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_record_kind   (out_record_kind),
  .out_pixel_address (out_pixel_address),
  .out_run_length    (out_run_length),
  .out_pixel_value   (out_pixel_value),
  .out_sprite_done   (out_sprite_done)
);

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking testbench for sprite_rle_planar_decoder
// Feeds run-length and planar sprite byte streams under a range of sprite
// sizes, predicts every write record in the testbench and compares each
// record taken from the result channel against the oldest prediction, with
// random idle bursts on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 20;
  localparam int QUIET_LIMIT  = 4000;
  localparam int ITEM_TARGET  = 310;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] addr;
    logic [7:0]  len;
    logic [7:0]  val;
    logic        done;
  } record_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = srpd_pkg::REG_MODE;
  logic [7:0]  cfg_wdata = 8'h00;
  logic        in_valid = 1'b0;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  out_record_kind;
  logic [15:0] out_pixel_address;
  logic [7:0]  out_run_length;
  logic [7:0]  out_pixel_value;
  logic        out_sprite_done;

  sprite_rle_planar_decoder uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_record_kind   (out_record_kind),
    .out_pixel_address (out_pixel_address),
    .out_run_length    (out_run_length),
    .out_pixel_value   (out_pixel_value),
    .out_sprite_done   (out_sprite_done)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Predictor state: configuration and decoder progress.
  logic        rle_mode;
  logic [7:0]  width_px;
  logic [7:0]  height_rows;
  int unsigned literal_left;
  int unsigned row_index;
  int unsigned write_pos;
  int unsigned row_base;
  int unsigned blk_idx;
  logic [7:0]  planes [4];
  logic        sprite_finished;

  logic [7:0]  sprite_bytes [$];
  record_t     pending_records [$];
  record_t     want_rec;
  int          stim_count = 0;
  int          mismatches = 0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_on = 1'b1;
  bit          calm = 1'b0;

  function automatic int unsigned row_stride();
    return ((int'(width_px) + 7) / 8) * 8;
  endfunction

  task automatic restart_sprite();
    literal_left = 0;
    row_index = 0;
    write_pos = 0;
    row_base = 0;
    blk_idx = 0;
    sprite_finished = 1'b0;
  endtask

  task automatic push_record(input logic [1:0] kind, input int unsigned addr,
                             input int unsigned len, input logic [7:0] val,
                             input logic done);
    record_t r;
    r.kind = kind;
    r.addr = addr[15:0];
    r.len  = len[7:0];
    r.val  = val;
    r.done = done;
    pending_records.push_back(r);
  endtask

  task automatic finish_row();
    int unsigned base;
    logic        last;
    base = row_base;
    row_index = (row_index + 1) & 32'hff;
    last = (row_index >= 32'(height_rows));
    if (last) sprite_finished = 1'b1;
    row_base = (row_base + row_stride()) & 32'hffff;
    write_pos = row_base;
    literal_left = 0;
    push_record(srpd_pkg::KIND_ROW_END, base, 0, 8'h00, last);
  endtask

  task automatic decode_byte(input logic [7:0] b);
    int unsigned store_end;
    int unsigned room;
    int unsigned cnt;
    int unsigned bw;
    int          sh;
    logic [7:0]  v;
    if (sprite_finished || width_px == 0 || height_rows == 0) return;
    bw = 32'(b);
    if (rle_mode) begin
      store_end = row_stride() * 32'(height_rows);
      room = (store_end > write_pos) ? store_end - write_pos : 0;
      if (literal_left > 0) begin
        push_record(srpd_pkg::KIND_PIXEL, write_pos, 1, b, 1'b0);
        write_pos = (write_pos + 1) & 32'hffff;
        literal_left--;
      end else if (bw == 0) begin
        finish_row();
      end else if (bw < 128) begin
        literal_left = (bw < room) ? bw : room;
      end else begin
        // Transparent run, clipped at the end of the store.
        cnt = 256 - bw;
        if (cnt > room) cnt = room;
        if (cnt != 0) begin
          push_record(srpd_pkg::KIND_FILL, write_pos, cnt, srpd_pkg::TRANSPARENT, 1'b0);
          write_pos = (write_pos + cnt) & 32'hffff;
        end
      end
    end else if (blk_idx < 4) begin
      planes[blk_idx] = b;
      blk_idx++;
    end else begin
      blk_idx = 0;
      for (int i = 0; i < 8; i++) begin
        sh = 7 - i;
        if (planes[0][sh]) v = srpd_pkg::TRANSPARENT;
        else v = {4'b0000, b[sh], planes[3][sh], planes[2][sh], planes[1][sh]};
        push_record(srpd_pkg::KIND_PIXEL, (write_pos + 32'(i)) & 32'hffff, 1, v, 1'b0);
      end
      write_pos = (write_pos + 8) & 32'hffff;
      if (write_pos - row_base >= row_stride()) finish_row();
    end
  endtask

  // Driver: presents queued bytes and predicts each accepted transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) decode_byte(in_data_byte);
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap--;
        end else if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
          in_valid <= 1'b0;
          in_gap = $urandom_range(0, 3);
        end else if (sprite_bytes.size() > 0) begin
          in_valid <= 1'b1;
          in_data_byte <= sprite_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted record and applies back-pressure.
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if (pending_records.size() == 0) begin
        $error("record with none expected: kind %0d, address %0d",
               out_record_kind, out_pixel_address);
        mismatches++;
      end else begin
        want_rec = pending_records.pop_front();
        if (out_record_kind !== want_rec.kind) begin
          $error("record_kind: expected %0d, got %0d", want_rec.kind, out_record_kind);
          mismatches++;
        end
        if (out_pixel_address !== want_rec.addr) begin
          $error("pixel_address: expected %0d, got %0d", want_rec.addr, out_pixel_address);
          mismatches++;
        end
        if (out_run_length !== want_rec.len) begin
          $error("run_length: expected %0d, got %0d", want_rec.len, out_run_length);
          mismatches++;
        end
        if (out_pixel_value !== want_rec.val) begin
          $error("pixel_value: expected %0d, got %0d", want_rec.val, out_pixel_value);
          mismatches++;
        end
        if (out_sprite_done !== want_rec.done) begin
          $error("sprite_done: expected %0d, got %0d", want_rec.done, out_sprite_done);
          mismatches++;
        end
      end
    end
    if (out_gap > 0) begin
      out_stall <= 1'b1;
      out_gap--;
    end else if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      out_gap = $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    sprite_bytes.push_back(b);
    stim_count++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      srpd_pkg::REG_MODE:   rle_mode = value[0];
      srpd_pkg::REG_WIDTH:  width_px = value;
      srpd_pkg::REG_HEIGHT: height_rows = value;
      default: ;
    endcase
    if (idx != REG_SPARE) restart_sprite();
  endtask

  // The upper bits of the mode write are random; only bit 0 counts.
  task automatic set_sprite(input logic m, input logic [7:0] w, input logic [7:0] h);
    logic [7:0] mode_word;
    mode_word = 8'($urandom);
    mode_word[0] = m;
    write_reg(srpd_pkg::REG_MODE, mode_word);
    if ($urandom_range(0, 1)) begin
      write_reg(srpd_pkg::REG_HEIGHT, h);
      write_reg(srpd_pkg::REG_WIDTH, w);
    end else begin
      write_reg(srpd_pkg::REG_WIDTH, w);
      write_reg(srpd_pkg::REG_HEIGHT, h);
    end
  endtask

  // Waits until every byte is taken and every record has come back, then
  // lets the pipeline settle in case trailing bytes were still in flight.
  task automatic drain();
    while (sprite_bytes.size() != 0 || in_valid) @(posedge clk);
    while (pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Well-formed rows of literal and transparent runs, with some noise bytes.
  task automatic gen_rle(input int budget);
    int start;
    int len;
    start = stim_count;
    while (stim_count - start < budget) begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 9))
          0: queue_byte(8'($urandom));
          1, 2, 3: queue_byte(8'($urandom_range(128, 255)));
          default: begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
            queue_byte(8'(len));
            repeat (len) queue_byte(8'($urandom));
          end
        endcase
      end
      queue_byte(8'h00);
    end
  endtask

  task automatic gen_planar(input int blocks);
    repeat (blocks) repeat (5) queue_byte(8'($urandom));
  endtask

  initial begin
    int phase_no;
    int pick;
    rle_mode = 1'b1;
    width_px = 8'd1;
    height_rows = 8'd1;
    foreach (planes[i]) planes[i] = 8'h00;
    restart_sprite();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset configuration: run-length, 1x1 sprite in an 8-pixel store.
    // Literal run whose pixels include 0 and 255, a fill clipped by the
    // store end, a fill and a literal clipped to nothing, then the row end
    // that finishes the sprite and a byte that must be ignored after it.
    foreach (sprite_bytes[i]) ;
    queue_byte(8'h03); queue_byte(8'h00); queue_byte(8'hff); queue_byte(8'h7f);
    queue_byte(8'h80); queue_byte(8'h81); queue_byte(8'h7f); queue_byte(8'h00);
    queue_byte(8'h44);
    drain();

    // A write to the unused index must change nothing.
    write_reg(REG_SPARE, 8'($urandom));
    write_reg(srpd_pkg::REG_MODE, 8'hfe);
    write_reg(srpd_pkg::REG_WIDTH, 8'd9);
    write_reg(srpd_pkg::REG_HEIGHT, 8'd1);
    queue_byte(8'ha5); queue_byte(8'hff); queue_byte(8'h00); queue_byte(8'hf0);
    queue_byte(8'h0f);
    queue_byte(8'h00); queue_byte(8'h55); queue_byte(8'h33); queue_byte(8'h0f);
    queue_byte(8'hff);
    queue_byte(8'h5a);
    drain();

    // Widest store: one full planar row of 32 blocks and one block past it.
    set_sprite(1'b0, 8'd255, 8'd1);
    gen_planar(33);
    drain();

    phase_no = 0;
    while (stim_count < ITEM_TARGET) begin
      pick = (phase_no < 6) ? phase_no : $urandom_range(0, 5);
      idle_on = ($urandom_range(0, 3) != 0);
      if (stim_count >= ITEM_TARGET - 50) calm = 1'b1;
      case (pick)
        0: begin
          set_sprite(1'b1, 8'd255, 8'd255);
          gen_rle($urandom_range(15, 30));
        end
        1: begin
          set_sprite(1'b1, 8'($urandom_range(1, 16)), 8'($urandom_range(1, 4)));
          gen_rle($urandom_range(15, 30));
        end
        2: begin
          set_sprite(1'b0, 8'($urandom_range(1, 24)), 8'($urandom_range(1, 3)));
          gen_planar($urandom_range(3, 6));
        end
        3: begin
          set_sprite(1'b1, 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
          gen_rle($urandom_range(15, 30));
        end
        4: begin
          // Empty sprite: every byte is dropped.
          if ($urandom_range(0, 1)) set_sprite(1'($urandom_range(0, 1)), 8'd0, 8'($urandom));
          else set_sprite(1'($urandom_range(0, 1)), 8'($urandom), 8'd0);
          gen_rle(8);
        end
        default: begin
          set_sprite(1'b0, 8'($urandom_range(1, 40)), 8'($urandom_range(1, 2)));
          gen_planar($urandom_range(3, 6));
        end
      endcase
      drain();
      phase_no++;
    end

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
